/* sv/font_rom_glyph_address_assert.svh */
// ----------------------------------------------------------------------------
// Font ROM glyph address - assertion macros
// Concurrent check macros shared by the RTL; compiled out under ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef FONT_ROM_GLYPH_ADDRESS_ASSERT_SVH
`define FONT_ROM_GLYPH_ADDRESS_ASSERT_SVH

`ifndef ASSERT_OFF

// Check that the consequent holds in the same cycle as the antecedent
`define FRGA_ASSERT_IMP(lbl, clk_i, rstn_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
	else $error("frga: same-cycle check failed");

// Check that the consequent holds in the cycle after the antecedent
`define FRGA_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
	else $error("frga: next-cycle check failed");

`else

`define FRGA_ASSERT_IMP(lbl, clk_i, rstn_i, ante, cons)
`define FRGA_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons)

`endif

`endif

/* sv/frga_pkg.sv */
// ----------------------------------------------------------------------------
// Font ROM glyph address - package
// Request/response types, opcodes and the constant tables of the ROM layout.
// ----------------------------------------------------------------------------
`default_nettype none

package frga_pkg;

	// Address bits carried by the ROM read command
	localparam int ADDR_BITS = 24;

	// Request opcodes
	typedef enum logic [2:0] {
		OP_ASCII_GLYPH = 3'd0,
		OP_ASCII_WIDTH = 3'd1,
		OP_GBK24       = 3'd2,
		OP_GB12        = 3'd3,
		OP_UNI_TABLE   = 3'd4
	} opcode_t;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [3:0]  font_kind;
		logic [15:0] char_code;
	} req_t;

	typedef struct packed {
		logic [ADDR_BITS-1:0] rom_address;
		logic [7:0]           read_length;
		logic                 valid_res;
	} rsp_t;

	// Printable ASCII window: above ASC_LOW_EXCL, up to ASC_HIGH
	localparam logic [7:0] ASC_LOW_EXCL = 8'h1F;
	localparam logic [7:0] ASC_HIGH     = 8'h7E;

	// Read lengths of the fixed-size requests
	localparam logic [7:0] LEN_WIDTH = 8'd2;
	localparam logic [7:0] LEN_GBK24 = 8'd72;
	localparam logic [7:0] LEN_GB12  = 8'd18;
	localparam logic [7:0] LEN_UNI   = 8'd2;

	// Glyph header bytes skipped by some ASCII styles
	localparam logic [ADDR_BITS-1:0] ASCII_HDR_BYTES = ADDR_BITS'(2);

	// ASCII style tables, indexed by font kind: base = mul * code + off
	localparam logic [7:0] ASCII_MUL [16] = '{
		8'd0, 8'd8, 8'd8, 8'd12, 8'd26, 8'd16, 8'd48, 8'd48,
		8'd64, 8'd34, 8'd74, 8'd130, 8'd0, 8'd0, 8'd0, 8'd0
	};
	localparam logic [ADDR_BITS-1:0] ASCII_OFF [16] = '{
		ADDR_BITS'(0),       ADDR_BITS'(2079456), ADDR_BITS'(2080224),
		ADDR_BITS'(2080864), ADDR_BITS'(2090144), ADDR_BITS'(2082784),
		ADDR_BITS'(1543800), ADDR_BITS'(1549944), ADDR_BITS'(2082784),
		ADDR_BITS'(2092384), ADDR_BITS'(1559864), ADDR_BITS'(2092576),
		ADDR_BITS'(0),       ADDR_BITS'(0),       ADDR_BITS'(0),
		ADDR_BITS'(0)
	};
	// Zero length marks an unknown style
	localparam logic [7:0] GLYPH_LEN [16] = '{
		8'd0, 8'd8, 8'd8, 8'd12, 8'd24, 8'd16, 8'd48, 8'd48,
		8'd64, 8'd32, 8'd72, 8'd130, 8'd0, 8'd0, 8'd0, 8'd0
	};
	localparam logic ASCII_HDR [16] = '{
		1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0,
		1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0
	};

	// 24-dot GBK index offsets per code zone
	localparam logic [ADDR_BITS-1:0] GBK_OFF_SYM   = ADDR_BITS'(15295);
	localparam logic [ADDR_BITS-1:0] GBK_OFF_ROW6  = ADDR_BITS'(15483);
	localparam logic [ADDR_BITS-1:0] GBK_OFF_ROW9  = ADDR_BITS'(15671);
	localparam logic [ADDR_BITS-1:0] GBK_OFF_HZ    = ADDR_BITS'(16250);
	localparam logic [ADDR_BITS-1:0] GBK_OFF_EXT_A = ADDR_BITS'(17351);
	localparam logic [ADDR_BITS-1:0] GBK_OFF_EXT_B = ADDR_BITS'(3081);

	// 12-dot GB2312 address offsets per zone (ROM base folded in)
	localparam logic [ADDR_BITS-1:0] GB12_OFF_ROW9 = ADDR_BITS'(2111340);
	localparam logic [ADDR_BITS-1:0] GB12_OFF_SYM  = ADDR_BITS'(1833906);
	localparam logic [ADDR_BITS-1:0] GB12_OFF_HZ   = ADDR_BITS'(1814970);

	// Unicode table: address = 2 * code + zone offset (table base folded in)
	localparam int UNI_ZONES = 14;
	localparam logic [ADDR_BITS-1:0] UNI_TABLE_BASE = ADDR_BITS'(2517590);
	localparam logic [15:0] UNI_LO [UNI_ZONES] = '{
		16'h00A0, 16'h2010, 16'h3000, 16'h4E00, 16'hFE30, 16'hFF01, 16'hFFE0,
		16'hF92C, 16'hE816, 16'h2E81, 16'h4947, 16'h4C77, 16'h3447, 16'h4055
	};
	localparam logic [15:0] UNI_HI [UNI_ZONES] = '{
		16'h0451, 16'h2642, 16'h33D5, 16'h9FA5, 16'hFE6B, 16'hFF5E, 16'hFFE5,
		16'hFA29, 16'hE864, 16'h2ECA, 16'h49B7, 16'h4DAE, 16'h3CE0, 16'h478D
	};
	localparam logic [ADDR_BITS-1:0] UNI_OFF [UNI_ZONES] = '{
		ADDR_BITS'(2517270), ADDR_BITS'(2503066), ADDR_BITS'(2498080),
		ADDR_BITS'(2484684), ADDR_BITS'(2436280), ADDR_BITS'(2435982),
		ADDR_BITS'(2435724), ADDR_BITS'(2439326), ADDR_BITS'(2448582),
		ADDR_BITS'(2543758), ADDR_BITS'(2530198), ADDR_BITS'(2528792),
		ADDR_BITS'(2541800), ADDR_BITS'(2540030)
	};

endpackage

`default_nettype wire

/* sv/frga_calc.sv */
// ----------------------------------------------------------------------------
// Font ROM glyph address - address calculation
// Maps one registered request to its ROM byte address and read length.
// ----------------------------------------------------------------------------
`default_nettype none

module frga_calc import frga_pkg::*; (
	input  req_t req,
	output rsp_t rsp
);

	logic [7:0]           lo;
	logic [7:0]           hi;
	logic                 ascii_ok;
	logic                 kind_ok;
	logic [15:0]          asc_prod;
	logic [ADDR_BITS-1:0] asc_base;
	logic [14:0]          row94;
	logic [15:0]          row190;
	logic [14:0]          row96;
	logic [7:0]           gbk_t;
	logic [ADDR_BITS-1:0] gbk_idx;
	logic [ADDR_BITS-1:0] gbk_addr;
	logic [14:0]          gb_row;
	logic [ADDR_BITS-1:0] gb_x;
	logic [ADDR_BITS-1:0] gb_off;
	logic [ADDR_BITS-1:0] gb_addr;
	logic                 uni_hit;
	logic [ADDR_BITS-1:0] uni_off;
	logic [ADDR_BITS-1:0] uni_addr;

	assign lo = req.char_code[7:0];
	assign hi = req.char_code[15:8];

	// ASCII: one small multiply by the style's stride plus the style base
	assign ascii_ok = (lo > ASC_LOW_EXCL) && (lo <= ASC_HIGH);
	assign kind_ok  = (GLYPH_LEN[req.font_kind] != 8'd0);
	assign asc_prod = ASCII_MUL[req.font_kind] * lo;
	assign asc_base = ADDR_BITS'(asc_prod) + ASCII_OFF[req.font_kind];

	// Row products of the double-byte codes
	assign row94  = hi * 15'd94;
	assign row190 = hi * 16'd190;
	assign row96  = hi * 15'd96;
	assign gbk_t  = lo[7] ? (lo - 8'd1) : lo;

	// 24-dot GBK: pick the zone index, then scale by the 72-byte glyph
	always_comb begin
		if (hi > 8'hAF && hi <= 8'hF7 && lo > 8'hA0) begin
			gbk_idx = ADDR_BITS'(row94) + ADDR_BITS'(lo) - GBK_OFF_HZ;
		end else if (hi <= 8'hA0 && hi > 8'h80 && lo > 8'h3F) begin
			gbk_idx = ADDR_BITS'(row190) + ADDR_BITS'(gbk_t) - GBK_OFF_EXT_A;
		end else if (hi > 8'hA9 && lo <= 8'hA0) begin
			gbk_idx = ADDR_BITS'(row96) + ADDR_BITS'(gbk_t) - GBK_OFF_EXT_B;
		end else if (hi > 8'hA0 && hi <= 8'hA3 && lo > 8'hA0) begin
			gbk_idx = ADDR_BITS'(row94) + ADDR_BITS'(lo) - GBK_OFF_SYM;
		end else if (hi == 8'hA6 && lo > 8'hA0) begin
			gbk_idx = ADDR_BITS'(row94) + ADDR_BITS'(lo) - GBK_OFF_ROW6;
		end else if (hi == 8'hA9 && lo > 8'hA0) begin
			gbk_idx = ADDR_BITS'(row94) + ADDR_BITS'(lo) - GBK_OFF_ROW9;
		end else begin
			gbk_idx = '0;
		end
	end
	assign gbk_addr = (gbk_idx << 6) + (gbk_idx << 3);

	// 12-dot GB2312: 18-byte glyphs, unmapped codes land on address zero
	assign gb_row = row94 + 15'(lo);
	always_comb begin
		gb_x   = '0;
		gb_off = '0;
		if (hi == 8'hA9 && lo > 8'hA3) begin
			gb_x   = ADDR_BITS'(lo);
			gb_off = GB12_OFF_ROW9;
		end else if (hi > 8'hA0 && hi <= 8'hA3 && lo > 8'hA0) begin
			gb_x   = ADDR_BITS'(gb_row);
			gb_off = GB12_OFF_SYM;
		end else if (hi > 8'hAF && hi <= 8'hF7 && lo > 8'hA0) begin
			gb_x   = ADDR_BITS'(gb_row);
			gb_off = GB12_OFF_HZ;
		end
	end
	assign gb_addr = (gb_x << 4) + (gb_x << 1) + gb_off;

	// Unicode table: compare against all zones, first zone in the list wins
	always_comb begin
		uni_hit = 1'b0;
		uni_off = UNI_TABLE_BASE;
		for (int i = UNI_ZONES - 1; i >= 0; i--) begin
			if (req.char_code >= UNI_LO[i] && req.char_code <= UNI_HI[i]) begin
				uni_hit = 1'b1;
				uni_off = UNI_OFF[i];
			end
		end
	end
	// Unmapped points read the table base itself
	assign uni_addr = uni_hit ? (ADDR_BITS'({req.char_code, 1'b0}) + uni_off) :
		UNI_TABLE_BASE;

	// Select the result by opcode; rejected requests read as all zero
	always_comb begin
		rsp = '0;
		case (opcode_t'(req.opcode))
			OP_ASCII_GLYPH: begin
				if (ascii_ok && kind_ok) begin
					rsp.valid_res   = 1'b1;
					rsp.read_length = GLYPH_LEN[req.font_kind];
					rsp.rom_address = ASCII_HDR[req.font_kind] ?
						asc_base + ASCII_HDR_BYTES : asc_base;
				end
			end
			OP_ASCII_WIDTH: begin
				if (ascii_ok && kind_ok) begin
					rsp.valid_res   = 1'b1;
					rsp.read_length = LEN_WIDTH;
					rsp.rom_address = asc_base;
				end
			end
			OP_GBK24: begin
				rsp.valid_res   = 1'b1;
				rsp.read_length = LEN_GBK24;
				rsp.rom_address = gbk_addr;
			end
			OP_GB12: begin
				rsp.valid_res   = 1'b1;
				rsp.read_length = LEN_GB12;
				rsp.rom_address = gb_addr;
			end
			OP_UNI_TABLE: begin
				rsp.valid_res   = 1'b1;
				rsp.read_length = LEN_UNI;
				rsp.rom_address = uni_addr;
			end
			default: begin
				rsp = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

/* sv/font_rom_glyph_address.sv */
// ----------------------------------------------------------------------------
// Font ROM glyph address - top level
// Request register, address calculation and response register.
// ----------------------------------------------------------------------------
// Takes one request per clock while rsp_stall is low, and returns one
// response for each, in order. A request is captured in the input register,
// the address and length are computed from it in a single pass of logic, and
// the result is held in the output register; the sustained rate is one request
// per cycle while the output is not stalled. The response register is
// the only point of back-pressure; req_stall follows rsp_stall within the
// same cycle when both registers are full. Requests outside the ASCII range,
// unknown styles and unused opcodes give a response with valid_res low and a
// zero address and length. Addresses are the low ADDR_BITS bits of the ROM
// byte address.
`default_nettype none

`include "font_rom_glyph_address_assert.svh"

module font_rom_glyph_address import frga_pkg::*; (
	input  logic clk,
	input  logic arst_n,

	input  logic req_valid,
	output logic req_stall,
	input  req_t req,

	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	req_t req_s1;
	logic vld_s1;
	rsp_t rsp_s2;
	logic vld_s2;
	rsp_t calc_rsp;
	logic s2_en;
	logic req_acc;

	// Advance when the response register is empty or being drained
	assign s2_en     = !vld_s2 || !rsp_stall;
	assign req_stall = vld_s1 && !s2_en;
	assign req_acc   = req_valid && !req_stall;

	frga_calc u_calc (
		.req (req_s1),
		.rsp (calc_rsp)
	);

	// Hold pipeline occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= req_acc || (vld_s1 && !s2_en);
			if (s2_en) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	// Capture payloads
	always_ff @(posedge clk) begin
		if (req_acc) begin
			req_s1 <= req;
		end
		if (s2_en && vld_s1) begin
			rsp_s2 <= calc_rsp;
		end
	end

	assign rsp_valid = vld_s2;
	assign rsp       = rsp_s2;

	// Checks
	`FRGA_ASSERT_IMP(a_full_stalls, clk, arst_n, vld_s1 && vld_s2 && rsp_stall, req_stall)
	`FRGA_ASSERT_NEXT(a_acc_fills_s1, clk, arst_n, req_valid && !req_stall, vld_s1)
	`FRGA_ASSERT_NEXT(a_s1_moves, clk, arst_n, vld_s1 && (!vld_s2 || !rsp_stall), vld_s2)
	`FRGA_ASSERT_IMP(a_reject_zero, clk, arst_n, vld_s2 && !rsp_s2.valid_res, rsp_s2.rom_address == '0 && rsp_s2.read_length == '0)
	`FRGA_ASSERT_IMP(a_issue_len, clk, arst_n, vld_s2 && rsp_s2.valid_res, rsp_s2.read_length != '0)

endmodule

`default_nettype wire

/* test/font_rom_glyph_address_checker.sv */
// ----------------------------------------------------------------------------
// Font ROM glyph address - response checker
// Watches both channels. It predicts the ROM address, read length and valid
// flag of every accepted request, then compares each accepted response with
// the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module font_rom_glyph_address_checker import frga_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_stall,
	input  req_t req,
	input  logic rsp_valid,
	input  logic rsp_stall,
	input  rsp_t rsp,
	output int   errors,
	output int   pending,
	output int   compared,
	output int   rejected
);
	timeunit 1ns;
	timeprecision 1ps;

	// Bytes per glyph for each ASCII style; zero marks an unknown style
	localparam bit [7:0] STYLE_BYTES [16] = '{
		8'd0, 8'd8, 8'd8, 8'd12, 8'd24, 8'd16, 8'd48, 8'd48,
		8'd64, 8'd32, 8'd72, 8'd130, 8'd0, 8'd0, 8'd0, 8'd0
	};

	rsp_t predicted_q[$];
	int   mismatch_count = 0;
	int   compare_count  = 0;
	int   reject_count   = 0;
	int   queued_count   = 0;

	assign errors   = mismatch_count;
	assign pending  = queued_count;
	assign compared = compare_count;
	assign rejected = reject_count;

	// Glyph origin of a printable code in one ASCII style, 32-bit wraparound
	function automatic bit [31:0] ascii_origin(bit [31:0] a, bit [3:0] style,
			output bit known);
		known = 1'b1;
		case (style)
			4'd1:    return 32'd8 * (a + 32'd259932);
			4'd2:    return 32'd8 * (a + 32'd260028);
			4'd3:    return 32'd12 * a + 32'd2080864;
			4'd4:    return 32'd26 * a + 32'd2090144;
			4'd5:    return 32'd16 * (a + 32'd130174);
			4'd6:    return 32'd48 * a + 32'd1543800;
			4'd7:    return 32'd48 * a + 32'd1549944;
			4'd8:    return ((a + 32'd67108832) << 6) + 32'd2084832;
			4'd9:    return 32'd34 * a + 32'd2092384;
			4'd10:   return 32'd74 * a + 32'd1559864;
			4'd11:   return 32'd130 * a + 32'd2092576;
			default: begin
				known = 1'b0;
				return 32'd0;
			end
		endcase
	endfunction

	// 24-dot GBK glyph offset; the later zones override the symbol rows
	function automatic bit [31:0] gbk24_offset(bit [31:0] c1, bit [31:0] c2);
		bit [31:0] idx;
		bit [31:0] t;
		idx = 32'd0;
		t   = c2;
		if (c1 > 32'hA0 && c1 <= 32'hA3 && c2 > 32'hA0)
			idx = 32'd94 * c1 + c2 - 32'd15295;
		else if (c1 == 32'd166 && c2 > 32'hA0)
			idx = 32'd94 * c1 + c2 - 32'd15483;
		else if (c1 == 32'd169 && c2 > 32'hA0)
			idx = 32'd94 * c1 + c2 - 32'd15671;
		if (c1 > 32'hAF && c1 <= 32'hF7 && c2 > 32'hA0) begin
			idx = 32'd94 * c1 + c2 - 32'd16250;
		end else if (c1 <= 32'hA0 && c1 > 32'h80 && c2 > 32'h3F) begin
			if (c2[7])
				t = c2 - 32'd1;
			idx = 32'd190 * c1 + t - 32'd17351;
		end else if (c1 > 32'hA9 && c2 <= 32'hA0) begin
			if (c2[7])
				t = c2 - 32'd1;
			idx = 32'd96 * c1 + t - 32'd3081;
		end
		return 32'd72 * idx;
	endfunction

	// 12-dot GB2312 glyph address; unmapped codes land on zero
	function automatic bit [31:0] gb12_offset(bit [31:0] m, bit [31:0] l);
		if (m == 32'd169 && l > 32'hA3)
			return 32'd18 * l + 32'd2109216 + 32'd2124;
		if (m > 32'hA0 && m <= 32'hA3 && l > 32'hA0)
			return 32'd18 * (32'd94 * m + l) + 32'd2109216 - 32'd275310;
		if (m > 32'hAF && m <= 32'hF7 && l > 32'hA0)
			return 32'd18 * (32'd94 * m + l) + 32'd2109216 - 32'd294246;
		return 32'd0;
	endfunction

	// Unicode-to-GBK table entry; unmapped points read the table base
	function automatic bit [31:0] unicode_entry(bit [31:0] u);
		bit [31:0] a;
		a = 32'd0;
		if (u > 32'h9F && u <= 32'h451)
			a = 32'd2 * (u + 32'd2147483488);
		else if (u > 32'h200F && u <= 32'h2642)
			a = 32'd2 * (u + 32'd2147475440) + 32'd1892;
		else if (u >= 32'h3000 && u <= 32'h33D5)
			a = 32'd2 * (u + 32'd2147471360) + 32'd5066;
		else if (u >= 32'h4E00 && u <= 32'h9FA5)
			a = 32'd2 * (u + 32'd2147463680) + 32'd7030;
		else if (u > 32'hFE2F && u <= 32'hFE6B)
			a = 32'd2 * (u + 32'd2147418576) + 32'd48834;
		else if (u > 32'hFF00 && u <= 32'hFF5E)
			a = 32'd2 * (u + 32'd2147418367) + 32'd48954;
		else if (u > 32'hFFDF && u <= 32'hFFE5)
			a = 32'd2 * (u + 32'd2147418144) + 32'd49142;
		else if (u > 32'hF92B && u <= 32'hFA29)
			a = 32'd2 * (u + 32'd2147419860) + 32'd49312;
		else if (u > 32'hE815 && u <= 32'hE864)
			a = 32'd2 * (u + 32'd2147424234) + 32'd49820;
		else if (u > 32'h2E80 && u <= 32'h2ECA)
			a = 32'd2 * (u + 32'd2147471743) + 32'd49978;
		else if (u > 32'h4946 && u <= 32'h49B7)
			a = 32'd2 * (u + 32'd2147464889) + 32'd50126;
		else if (u > 32'h4C76 && u <= 32'h4DAE)
			a = 32'd2 * (u + 32'd2147464073) + 32'd50352;
		else if (u > 32'h3446 && u <= 32'h3CE0)
			a = 32'd2 * (u + 32'd2147470265) + 32'd50976;
		else if (u > 32'h4054 && u <= 32'h478D)
			a = 32'd2 * (u + 32'd2147467178) + 32'd55380;
		return a + 32'd2517590;
	endfunction

	function automatic rsp_t rom_read_for(req_t r);
		rsp_t      p;
		bit [31:0] lo;
		bit [31:0] hi;
		bit [31:0] base;
		bit [31:0] addr;
		bit [7:0]  len;
		bit        known;
		bit        issued;
		lo     = {24'd0, r.char_code[7:0]};
		hi     = {24'd0, r.char_code[15:8]};
		addr   = 32'd0;
		len    = 8'd0;
		issued = 1'b0;
		case (r.opcode)
			OP_ASCII_GLYPH, OP_ASCII_WIDTH: begin
				// Only printable codes in a known style issue a read
				if (lo > 32'h1F && lo <= 32'h7E) begin
					base = ascii_origin(lo, r.font_kind, known);
					if (known) begin
						issued = 1'b1;
						if (r.opcode == OP_ASCII_WIDTH) begin
							addr = base;
							len  = 8'd2;
						end else begin
							// Skip the width header of the proportional styles
							if (r.font_kind == 4'd4 || r.font_kind == 4'd9 ||
									r.font_kind == 4'd10)
								addr = base + 32'd2;
							else
								addr = base;
							len = STYLE_BYTES[r.font_kind];
						end
					end
				end
			end
			OP_GBK24: begin
				addr   = gbk24_offset(hi, lo);
				len    = 8'd72;
				issued = 1'b1;
			end
			OP_GB12: begin
				addr   = gb12_offset(hi, lo);
				len    = 8'd18;
				issued = 1'b1;
			end
			OP_UNI_TABLE: begin
				addr   = unicode_entry({16'd0, r.char_code});
				len    = 8'd2;
				issued = 1'b1;
			end
			default: ;
		endcase
		p.rom_address = addr[ADDR_BITS-1:0];
		p.read_length = len;
		p.valid_res   = issued;
		return p;
	endfunction

	// Compare accepted responses, then queue the prediction of an accepted request
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (predicted_q.size() == 0) begin
					mismatch_count++;
					$error("response with no request outstanding: %0h", rsp);
				end else begin
					want = predicted_q.pop_front();
					compare_count++;
					if (!want.valid_res)
						reject_count++;
					if (rsp.rom_address !== want.rom_address) begin
						mismatch_count++;
						$error("rom_address: expected %0h, got %0h",
							want.rom_address, rsp.rom_address);
					end
					if (rsp.read_length !== want.read_length) begin
						mismatch_count++;
						$error("read_length: expected %0d, got %0d",
							want.read_length, rsp.read_length);
					end
					if (rsp.valid_res !== want.valid_res) begin
						mismatch_count++;
						$error("valid_res: expected %0b, got %0b",
							want.valid_res, rsp.valid_res);
					end
				end
			end
			if (req_valid && !req_stall)
				predicted_q.push_back(rom_read_for(req));
			queued_count <= predicted_q.size();
		end
	end

endmodule

/* test/font_rom_glyph_address_tb.sv */
// ----------------------------------------------------------------------------
// Font ROM glyph address - testbench
// Drives directed and random character requests through the block under
// four flow-control modes and reports the checker's verdict.
// ----------------------------------------------------------------------------
module font_rom_glyph_address_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import frga_pkg::*;

	localparam int RANDOM_REQUESTS = 1252;
	localparam int CYCLE_LIMIT     = 200000;
	localparam int DRAIN_CYCLES    = 8;

	// Opcodes the block does not define
	localparam logic [2:0] OP_SPARE_5 = 3'd5;
	localparam logic [2:0] OP_SPARE_7 = 3'd7;

	// Mapped Unicode zones, first and last code point
	localparam bit [15:0] UNI_FIRST [14] = '{
		16'h00A0, 16'h2010, 16'h3000, 16'h4E00, 16'hFE30, 16'hFF01, 16'hFFE0,
		16'hF92C, 16'hE816, 16'h2E81, 16'h4947, 16'h4C77, 16'h3447, 16'h4055
	};
	localparam bit [15:0] UNI_LAST [14] = '{
		16'h0451, 16'h2642, 16'h33D5, 16'h9FA5, 16'hFE6B, 16'hFF5E, 16'hFFE5,
		16'hFA29, 16'hE864, 16'h2ECA, 16'h49B7, 16'h4DAE, 16'h3CE0, 16'h478D
	};

	typedef enum int {FLOW_FREE, FLOW_SENDER_IDLE, FLOW_RECEIVER_STALL, FLOW_BOTH} flow_t;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	int errors;
	int pending;
	int compared;
	int rejected;
	int gap_pct     = 0;
	int stall_pct   = 0;
	int sent        = 0;
	int cycle_count = 0;

	font_rom_glyph_address dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	font_rom_glyph_address_checker checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.errors    (errors),
		.pending   (pending),
		.compared  (compared),
		.rejected  (rejected)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Stall the response channel at the rate of the current mode
	always @(posedge clk) begin
		rsp_stall <= ($urandom_range(99) < stall_pct);
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("font_rom_glyph_address verification failed");
			$finish;
		end
	end

	task automatic set_flow(flow_t mode);
		case (mode)
			FLOW_FREE: begin
				gap_pct = 0;
				stall_pct <= 0;
			end
			FLOW_SENDER_IDLE: begin
				gap_pct = 69;
				stall_pct <= 0;
			end
			FLOW_RECEIVER_STALL: begin
				gap_pct = 0;
				stall_pct <= 69;
			end
			default: begin
				gap_pct = 26;
				stall_pct <= 26;
			end
		endcase
	endtask

	// Offer one request, with random idle cycles ahead of it, and hold until taken
	task automatic send_request(req_t item);
		while ($urandom_range(99) < gap_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		sent++;
	endtask

	// Mostly well-formed codes for each opcode, with some raw noise
	function automatic req_t random_request();
		req_t r;
		int   zone;
		r = req_t'(23'($urandom));
		if ($urandom_range(9) == 0)
			return r;
		r.opcode    = 3'($urandom_range(4));
		r.font_kind = 4'($urandom_range(11, 1));
		case (r.opcode)
			OP_ASCII_GLYPH, OP_ASCII_WIDTH: begin
				if ($urandom_range(9) == 0)
					r.font_kind = 4'($urandom);
				if ($urandom_range(9) != 0)
					r.char_code[7:0] = 8'($urandom_range(8'h7E, 8'h20));
			end
			OP_GBK24: begin
				case ($urandom_range(5))
					0: r.char_code[15:8] = 8'($urandom_range(8'hA3, 8'hA1));
					1: r.char_code[15:8] = $urandom_range(1) ? 8'hA6 : 8'hA9;
					2: r.char_code[15:8] = 8'($urandom_range(8'hF7, 8'hB0));
					3: r.char_code[15:8] = 8'($urandom_range(8'hA0, 8'h81));
					4: r.char_code[15:8] = 8'($urandom_range(8'hFF, 8'hAA));
					default: ;
				endcase
				if ($urandom_range(1))
					r.char_code[7:0] = 8'($urandom_range(8'hFE, 8'hA1));
			end
			OP_GB12: begin
				case ($urandom_range(3))
					0: r.char_code[15:8] = 8'hA9;
					1: r.char_code[15:8] = 8'($urandom_range(8'hA3, 8'hA1));
					2: r.char_code[15:8] = 8'($urandom_range(8'hF7, 8'hB0));
					default: ;
				endcase
				if ($urandom_range(1))
					r.char_code[7:0] = 8'($urandom_range(8'hFE, 8'hA1));
			end
			default: begin
				// Hit zone edges often, interiors otherwise
				zone = $urandom_range(13);
				case ($urandom_range(8))
					0: r.char_code = UNI_FIRST[zone] - 16'd1;
					1: r.char_code = UNI_FIRST[zone];
					2: r.char_code = UNI_LAST[zone];
					3: r.char_code = UNI_LAST[zone] + 16'd1;
					4: ;
					default: r.char_code = 16'($urandom_range(UNI_LAST[zone], UNI_FIRST[zone]));
				endcase
			end
		endcase
		return r;
	endfunction

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: ASCII styles at the window edges, header skip, shift wrap
		set_flow(FLOW_FREE);
		send_request('{OP_ASCII_GLYPH, 4'd1,  16'h0020});
		send_request('{OP_ASCII_GLYPH, 4'd11, 16'h007E});
		send_request('{OP_ASCII_GLYPH, 4'd4,  16'h0041});
		send_request('{OP_ASCII_GLYPH, 4'd8,  16'h007E});
		send_request('{OP_ASCII_GLYPH, 4'd9,  16'hFF41});
		send_request('{OP_ASCII_WIDTH, 4'd10, 16'h0020});
		// Directed: rejected ASCII codes and styles
		send_request('{OP_ASCII_GLYPH, 4'd1,  16'h001F});
		send_request('{OP_ASCII_GLYPH, 4'd2,  16'h007F});
		send_request('{OP_ASCII_WIDTH, 4'd0,  16'h0041});
		send_request('{OP_ASCII_GLYPH, 4'd15, 16'h0041});
		// Directed: every GBK zone and an unmapped code
		send_request('{OP_GBK24, 4'd0,  16'hA1A1});
		send_request('{OP_GBK24, 4'd0,  16'hA6A1});
		send_request('{OP_GBK24, 4'd0,  16'hA9FE});
		send_request('{OP_GBK24, 4'd0,  16'hF7FE});
		send_request('{OP_GBK24, 4'd0,  16'h8140});
		send_request('{OP_GBK24, 4'd15, 16'hFEA0});
		send_request('{OP_GBK24, 4'd0,  16'h0000});
		// Directed: two of the 12-dot zones and an unmapped code
		send_request('{OP_GB12, 4'd0, 16'hA9A4});
		send_request('{OP_GB12, 4'd0, 16'hA1A1});
		send_request('{OP_GB12, 4'd0, 16'hA9A3});
		// Directed: Unicode zone edges and an unmapped point
		send_request('{OP_UNI_TABLE, 4'd0, 16'h00A0});
		send_request('{OP_UNI_TABLE, 4'd0, 16'h9FA5});
		send_request('{OP_UNI_TABLE, 4'd0, 16'hFFFF});
		// Directed: undefined opcodes
		send_request('{OP_SPARE_5, 4'd15, 16'hFFFF});
		send_request('{OP_SPARE_7, 4'd0,  16'h0000});

		// Random requests, a quarter under each flow-control mode
		for (int m = 0; m < 4; m++) begin
			set_flow(flow_t'(m));
			repeat (RANDOM_REQUESTS / 4)
				send_request(random_request());
		end
		req_valid <= 1'b0;
		set_flow(FLOW_FREE);

		// Drain outstanding responses, then allow the pipeline to settle
		do
			@(posedge clk);
		while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Drove %0d requests; %0d responses compared, %0d of them rejections,",
			sent, compared, rejected);
		$display("under free flow, sender gaps, receiver stalls and both together.");
		if (errors == 0 && pending == 0)
			$display("font_rom_glyph_address verification clean");
		else
			$display("font_rom_glyph_address verification failed");
		$finish;
	end

endmodule
